[rtl/assert_macros.svh]
// Assertion macros for the top-level RTL file of the dechunker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hrd_pkg.sv]
// Types, constants and byte classification functions for the dechunker.
`timescale 1ns / 1ps

package hrd_pkg;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_BODY     = 3'd1,
    PH_SKIP_PRE = 3'd2,
    PH_SIZE     = 3'd3,
    PH_RUN_REST = 3'd4,
    PH_SKIP_ONE = 3'd5,
    PH_PAYLOAD  = 3'd6,
    PH_DONE     = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    kind_e      kind;
  } result_t;

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  // Value of a hex digit; only meaningful when is_hex() holds.
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b <= 8'h46) begin
      v = b - 8'h37;
    end else begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

[rtl/hrd_in_if.sv]
// Request channel carrying response bytes into the dechunker.
`timescale 1ns / 1ps

interface hrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_response;

  modport source (output valid, output in_byte, output start_of_response, input ready);
  modport sink   (input valid, input in_byte, input start_of_response, output ready);
endinterface

[rtl/hrd_out_if.sv]
// Request channel carrying classified bytes and markers out of the dechunker.
`timescale 1ns / 1ps

interface hrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;

  modport source (output valid, output out_byte, output byte_kind, input ready);
  modport sink   (input valid, input out_byte, input byte_kind, output ready);
endinterface

[rtl/http_response_dechunker.sv]
// Data path: a byte accepted into the input register is parsed as it moves
//   into the output register; bytes that cause no result are simply consumed.
// Throughput: one byte per cycle while the output is not stalled.
// Reset (rst_ni low, asynchronous): both stages empty, parser in header phase
//   with all counters zero, chunked mode off.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module http_response_dechunker import hrd_pkg::*; #(
  parameter int SIZE_DIGITS = 7
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  hrd_in_if.sink   in_i,
  hrd_out_if.source out_o
);

  logic       chunked_en_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_sor_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  kind_e      out_kind_q;

  logic       advance, step, in_ready;
  result_t    res;

  // The input register moves on whenever the output register is free or drained.
  assign advance  = !out_valid_q || out_o.ready;
  assign step     = s1_valid_q && advance;
  assign in_ready = !s1_valid_q || advance;

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.byte_kind = out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunked_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      chunked_en_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_byte_q <= in_i.in_byte;
      s1_sor_q  <= in_i.start_of_response;
    end
  end

  hrd_parser #(
    .SIZE_DIGITS(SIZE_DIGITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (s1_byte_q),
    .sor_i       (s1_sor_q),
    .chunked_en_i(chunked_en_q),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_byte_q <= res.data;
      out_kind_q <= res.kind;
    end
  end

  `ASSERT_NEXT(a_s1_hold, s1_valid_q && !advance, s1_valid_q && $stable(s1_byte_q), "input stage lost a stalled byte")
  `ASSERT_IMPL(a_ready_stall, !in_ready, out_valid_q && !out_o.ready, "input stalled without output backpressure")
  `ASSERT_IMPL(a_marker_zero, step && res.valid && (res.kind == KIND_END || res.kind == KIND_ERROR), res.data == 8'h00, "marker result carries a nonzero byte")

endmodule

[rtl/hrd_parser.sv]
// Parser state machine: header terminator match, chunk size read and payload count.
`timescale 1ns / 1ps

module hrd_parser import hrd_pkg::*; #(
  parameter int SIZE_DIGITS = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       sor_i,
  input  logic       chunked_en_i,
  output result_t    result_o
);

  localparam int AccW = 4 * SIZE_DIGITS;
  localparam int CntW = $clog2(SIZE_DIGITS + 1);

  phase_e            phase_q, phase_d, phase_c;
  logic [1:0]        term_q, term_d, term_c;
  logic [AccW-1:0]   accum_q, accum_d, accum_c, accum_shift;
  logic [CntW-1:0]   count_q, count_d, count_c;
  logic [AccW-1:0]   left_q, left_d, left_c, left_dec;

  logic       alnum, hexd, term_hit, count_full;
  logic [3:0] hexv;

  // A start of response clears the parser before this byte is handled.
  always_comb begin
    phase_c = sor_i ? PH_HEADER : phase_q;
    term_c  = sor_i ? 2'd0 : term_q;
    accum_c = sor_i ? '0 : accum_q;
    count_c = sor_i ? '0 : count_q;
    left_c  = sor_i ? '0 : left_q;
  end

  assign alnum       = is_alnum(byte_i);
  assign hexd        = is_hex(byte_i);
  assign hexv        = hex_value(byte_i);
  assign term_hit    = (byte_i == (term_c[0] ? CHAR_LF : CHAR_CR));
  assign count_full  = (count_c == CntW'(SIZE_DIGITS));
  assign accum_shift = (accum_c << 4) | AccW'(hexv);
  assign left_dec    = (left_c != '0) ? left_c - AccW'(1) : left_c;

  // Next phase.
  always_comb begin
    phase_d = phase_c;
    case (phase_c)
      PH_HEADER: begin
        if (term_hit && term_c == 2'd3) begin
          phase_d = chunked_en_i ? PH_SKIP_PRE : PH_BODY;
        end
      end
      PH_BODY: phase_d = PH_BODY;
      PH_SKIP_PRE: begin
        if (alnum) begin
          phase_d = hexd ? PH_SIZE : PH_RUN_REST;
        end
      end
      PH_SIZE: begin
        if (!alnum) begin
          phase_d = (accum_c == '0) ? PH_DONE : PH_SKIP_ONE;
        end else if (!hexd) begin
          phase_d = PH_RUN_REST;
        end else if (count_full) begin
          phase_d = PH_DONE;
        end
      end
      PH_RUN_REST: begin
        if (!alnum) begin
          phase_d = (accum_c == '0) ? PH_DONE : PH_SKIP_ONE;
        end
      end
      PH_SKIP_ONE: phase_d = PH_PAYLOAD;
      PH_PAYLOAD: begin
        if (left_dec == '0) begin
          phase_d = PH_SKIP_PRE;
        end
      end
      PH_DONE: phase_d = PH_DONE;
      default: phase_d = PH_DONE;
    endcase
  end

  // Result and datapath updates.
  always_comb begin
    result_o = '{valid: 1'b0, data: 8'h00, kind: KIND_HEADER};
    term_d   = term_c;
    accum_d  = accum_c;
    count_d  = count_c;
    left_d   = left_c;
    case (phase_c)
      PH_HEADER: begin
        if (term_hit) begin
          term_d = (term_c == 2'd3) ? 2'd0 : term_c + 2'd1;
        end else begin
          // A CR that breaks a partial match starts a new one.
          term_d = (byte_i == CHAR_CR) ? 2'd1 : 2'd0;
        end
        result_o = '{valid: 1'b1, data: byte_i, kind: KIND_HEADER};
      end
      PH_BODY: result_o = '{valid: 1'b1, data: byte_i, kind: KIND_BODY};
      PH_SKIP_PRE: begin
        if (alnum) begin
          accum_d = hexd ? AccW'(hexv) : '0;
          count_d = hexd ? CntW'(1) : '0;
        end
      end
      PH_SIZE: begin
        if (!alnum) begin
          left_d = accum_c;
          if (accum_c == '0) begin
            result_o = '{valid: 1'b1, data: 8'h00, kind: KIND_END};
          end
        end else if (hexd) begin
          if (count_full) begin
            result_o = '{valid: 1'b1, data: 8'h00, kind: KIND_ERROR};
          end else begin
            accum_d = accum_shift;
            count_d = count_c + CntW'(1);
          end
        end
      end
      PH_RUN_REST: begin
        if (!alnum) begin
          left_d = accum_c;
          if (accum_c == '0) begin
            result_o = '{valid: 1'b1, data: 8'h00, kind: KIND_END};
          end
        end
      end
      PH_PAYLOAD: begin
        left_d   = left_dec;
        result_o = '{valid: 1'b1, data: byte_i, kind: KIND_BODY};
      end
      default: begin
        result_o = '{valid: 1'b0, data: 8'h00, kind: KIND_HEADER};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      term_q  <= 2'd0;
      accum_q <= '0;
      count_q <= '0;
      left_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      term_q  <= term_d;
      accum_q <= accum_d;
      count_q <= count_d;
      left_q  <= left_d;
    end
  end

endmodule

[tb/dechunk_checker.sv]
// Checker for the dechunker: predicts the result stream from accepted requests and compares.
`timescale 1ns / 1ps

module dechunk_checker import hrd_pkg::*; #(
  parameter int SIZE_DIGITS = 7
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  hrd_in_if    in_ch,
  hrd_out_if   out_ch,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int SIZE_BITS = 4 * SIZE_DIGITS;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } decoded_t;

  decoded_t             predicted_q[$];
  logic                 chunked_mode;
  phase_e               parse_phase;
  logic [1:0]           crlf_seen;
  logic [SIZE_BITS-1:0] size_acc;
  int                   digit_cnt;
  logic [SIZE_BITS-1:0] bytes_left;

  function automatic logic is_word_char(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  // Returns 16 for anything that is not a hex digit.
  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd16;
    if (b >= "0" && b <= "9") begin
      v = b - "0";
    end else if (b >= "a" && b <= "f") begin
      v = b - "a" + 8'd10;
    end else if (b >= "A" && b <= "F") begin
      v = b - "A" + 8'd10;
    end
    return v[4:0];
  endfunction

  task automatic restart_parse();
    parse_phase = PH_HEADER;
    crlf_seen   = 2'd0;
    size_acc    = '0;
    digit_cnt   = 0;
    bytes_left  = '0;
  endtask

  // The byte that ends a size run; a zero size closes the body.
  task automatic close_size(inout logic hit, inout decoded_t r);
    if (size_acc == '0) begin
      parse_phase = PH_DONE;
      hit         = 1'b1;
      r.data      = 8'h00;
      r.kind      = KIND_END;
    end else begin
      bytes_left  = size_acc;
      parse_phase = PH_SKIP_ONE;
    end
  endtask

  task automatic take_digit(input logic [3:0] v, inout logic hit, inout decoded_t r);
    if (digit_cnt >= SIZE_DIGITS) begin
      parse_phase = PH_DONE;
      hit         = 1'b1;
      r.data      = 8'h00;
      r.kind      = KIND_ERROR;
    end else begin
      size_acc  = {size_acc[SIZE_BITS-5:0], v};
      digit_cnt = digit_cnt + 1;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic sor,
                             output logic hit, output decoded_t r);
    logic [4:0] nib;
    hit    = 1'b0;
    r.data = 8'h00;
    r.kind = KIND_HEADER;
    nib    = nibble_of(b);
    if (sor) restart_parse();
    case (parse_phase)
      PH_HEADER: begin
        // The terminator alternates CR and LF. A CR that breaks a partial match
        // starts a new one.
        if (b == (crlf_seen[0] ? CHAR_LF : CHAR_CR)) begin
          if (crlf_seen == 2'd3) begin
            crlf_seen   = 2'd0;
            parse_phase = chunked_mode ? PH_SKIP_PRE : PH_BODY;
          end else begin
            crlf_seen = crlf_seen + 2'd1;
          end
        end else begin
          crlf_seen = (b == CHAR_CR) ? 2'd1 : 2'd0;
        end
        hit    = 1'b1;
        r.data = b;
      end
      PH_BODY: begin
        hit    = 1'b1;
        r.data = b;
        r.kind = KIND_BODY;
      end
      PH_SKIP_PRE: begin
        if (is_word_char(b)) begin
          size_acc  = '0;
          digit_cnt = 0;
          if (nib[4]) begin
            parse_phase = PH_RUN_REST;
          end else begin
            parse_phase = PH_SIZE;
            take_digit(nib[3:0], hit, r);
          end
        end
      end
      PH_SIZE: begin
        if (!is_word_char(b)) begin
          close_size(hit, r);
        end else if (nib[4]) begin
          parse_phase = PH_RUN_REST;
        end else begin
          take_digit(nib[3:0], hit, r);
        end
      end
      PH_RUN_REST: begin
        if (!is_word_char(b)) close_size(hit, r);
      end
      PH_SKIP_ONE: begin
        parse_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (bytes_left != '0) bytes_left = bytes_left - SIZE_BITS'(1);
        if (bytes_left == '0) parse_phase = PH_SKIP_PRE;
        hit    = 1'b1;
        r.data = b;
        r.kind = KIND_BODY;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic     hit;
    decoded_t item;
    decoded_t want;
    if (!rst_ni) begin
      restart_parse();
      chunked_mode = 1'b0;
      predicted_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.in_byte, in_ch.start_of_response, hit, item);
        if (hit) predicted_q.push_back(item);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_q.size() == 0) begin
          $error("result with none expected: out_byte %02h byte_kind %0d",
                 out_ch.out_byte, out_ch.byte_kind);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = predicted_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   want.data, out_ch.out_byte);
            fail_count_o = fail_count_o + 1;
          end
          if (out_ch.byte_kind !== want.kind) begin
            $error("byte_kind mismatch: expected %0d, actual %0d",
                   want.kind, out_ch.byte_kind);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) chunked_mode = cfg_wdata_i;
    end
    pending_o = predicted_q.size();
  end

endmodule

[tb/testbench.sv]
// Testbench top for the dechunker: clock, reset, response stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import hrd_pkg::*;

  localparam int SIZE_DIGITS   = 7;
  localparam int ITEM_GOAL     = 1150;
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic cfg_wdata;
  int   fail_count;
  int   pending;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   items_sent;
  int   hold_offs_asked;
  logic chunked;

  hrd_in_if  in_ch ();
  hrd_out_if out_ch ();

  http_response_dechunker #(.SIZE_DIGITS(SIZE_DIGITS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  dechunk_checker #(.SIZE_DIGITS(SIZE_DIGITS)) decode_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin
    int hold_left;
    int hold_offs_done;
    hold_left      = 0;
    hold_offs_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_offs_done != hold_offs_asked) begin
        hold_offs_done = hold_offs_done + 1;
        hold_left      = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] base;
    base = $urandom_range(1) ? "A" : "a";
    if (v < 4'd10) return 8'h30 + 8'(v);
    return base + 8'(v) - 8'd10;
  endfunction

  // A letter beyond F, in either case.
  function automatic logic [7:0] pick_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? "g" : "G";
    return base + 8'($urandom_range(19));
  endfunction

  // Any byte that is neither a digit nor a letter, including those above 127.
  function automatic logic [7:0] pick_separator();
    case ($urandom_range(4))
      0: return 8'($urandom_range(47));
      1: return 8'($urandom_range(128, 255));
      2: return 8'($urandom_range(58, 64));
      3: return 8'($urandom_range(91, 96));
      default: return 8'($urandom_range(123, 127));
    endcase
  endfunction

  function automatic logic [7:0] header_char();
    case ($urandom_range(9))
      0: return CHAR_CR;
      1: return CHAR_LF;
      2: return 8'($urandom_range(255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  // Offers one request and returns at the edge that accepts it.
  task automatic put_byte(input logic [7:0] b, input logic sor, input logic counted);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid             <= 1'b1;
    in_ch.in_byte           <= b;
    in_ch.start_of_response <= sor;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (counted) items_sent = items_sent + 1;
  endtask

  // Waits until every predicted result has come out and the pipeline is empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic en);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    chunked = en;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic send_header_end(input logic sor);
    put_byte(CHAR_CR, sor, 1'b1);
    put_byte(CHAR_LF, 1'b0, 1'b1);
    put_byte(CHAR_CR, 1'b0, 1'b1);
    put_byte(CHAR_LF, 1'b0, 1'b1);
  endtask

  // Hex size digits, an optional letter followed by up to two hex digits, then the two skipped bytes.
  task automatic send_size_line(input logic [27:0] value, input int ndig);
    for (int i = ndig - 1; i >= 0; i--) begin
      put_byte(hex_char(4'(value >> (4 * i))), 1'b0, 1'b1);
    end
    if ($urandom_range(3) == 0) begin
      put_byte(pick_letter(), 1'b0, 1'b1);
      repeat ($urandom_range(2)) put_byte(hex_char(4'($urandom_range(15))), 1'b0, 1'b1);
    end
    put_byte(($urandom_range(3) != 0) ? CHAR_CR : pick_separator(), 1'b0, 1'b1);
    put_byte(($urandom_range(3) != 0) ? CHAR_LF : 8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic send_response();
    int          size;
    logic [27:0] big;
    put_byte(header_char(), 1'b1, 1'b1);
    repeat ($urandom_range(4)) put_byte(header_char(), 1'b0, 1'b1);
    send_header_end(1'b0);
    if (!chunked) begin
      repeat ($urandom_range(16)) put_byte(8'($urandom_range(255)), 1'b0, 1'b1);
      return;
    end
    repeat ($urandom_range(3)) begin
      if ($urandom_range(3) == 0) put_byte(pick_separator(), 1'b0, 1'b1);
      size = $urandom_range(1, 20);
      send_size_line(28'(size), ($urandom_range(11) == 0) ? SIZE_DIGITS :
                                ((size > 15) ? 2 : 1) + $urandom_range(1));
      repeat (size) put_byte(8'($urandom_range(255)), 1'b0, 1'b1);
      put_byte(CHAR_CR, 1'b0, 1'b1);
      put_byte(CHAR_LF, 1'b0, 1'b1);
    end
    case ($urandom_range(9))
      0, 1: begin
        send_size_line(28'($urandom), SIZE_DIGITS + 1 + $urandom_range(1));
      end
      2: begin
        // Too large to finish; the next response cuts the chunk short.
        big = $urandom_range(1) ? 28'hFFFFFFF : (28'($urandom) | 28'h1000000);
        send_size_line(big, SIZE_DIGITS);
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(255)), 1'b0, 1'b1);
      end
      3: begin
        put_byte(pick_letter(), 1'b0, 1'b1);
        put_byte(pick_separator(), 1'b0, 1'b1);
      end
      default: begin
        send_size_line(28'd0, $urandom_range(1, 3));
      end
    endcase
    repeat ($urandom_range(2)) put_byte(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      put_byte(8'($urandom_range(255)), $urandom_range(7) == 0, 1'b1);
    end
  endtask

  initial begin
    rst_ni                  <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.in_byte           <= 8'h00;
    in_ch.start_of_response <= 1'b0;
    chunked         = 1'b0;
    items_sent      = 0;
    hold_offs_asked = 0;
    src_idle_pct    = 16;
    sink_idle_pct   = 55;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Header whose third CR breaks a partial match, then plain body bytes.
    put_byte(CHAR_CR, 1'b1, 1'b1);
    put_byte(CHAR_LF, 1'b0, 1'b1);
    put_byte(CHAR_CR, 1'b0, 1'b1);
    put_byte(CHAR_CR, 1'b0, 1'b1);
    put_byte(CHAR_LF, 1'b0, 1'b1);
    put_byte(CHAR_CR, 1'b0, 1'b1);
    put_byte(CHAR_LF, 1'b0, 1'b1);
    put_byte(8'h00, 1'b0, 1'b1);
    put_byte(8'hFF, 1'b0, 1'b1);
    // Chunked mode only takes effect at the end of the next header.
    settle();
    write_mode(1'b1);
    put_byte("A", 1'b0, 1'b1);
    send_header_end(1'b1);
    // Size 1 ended by a letter, a byte above 127 closing the run, one payload byte,
    // then a run without a hex prefix that closes the body.
    put_byte(" ", 1'b0, 1'b1);
    put_byte("1", 1'b0, 1'b1);
    put_byte("g", 1'b0, 1'b1);
    put_byte("7", 1'b0, 1'b1);
    put_byte(8'hC1, 1'b0, 1'b1);
    put_byte("Z", 1'b0, 1'b1);
    put_byte(8'h80, 1'b0, 1'b1);
    put_byte("x", 1'b0, 1'b1);
    put_byte(CHAR_LF, 1'b0, 1'b1);
    put_byte("3", 1'b0, 1'b0);

    for (int seg = 0; seg < 6; seg++) begin
      src_idle_pct  = (seg < 2) ? 16 : ((seg < 4) ? 55 : 0);
      sink_idle_pct = (seg < 2) ? 55 : ((seg < 4) ? 16 : 0);
      settle();
      write_mode((seg % 3) != 1);
      if (seg == 4) hold_offs_asked = hold_offs_asked + 1;
      while (items_sent < ITEM_GOAL * (seg + 1) / 6) begin
        if ($urandom_range(9) == 0) begin
          send_noise();
        end else begin
          send_response();
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
